// File: design/wlqs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the windowed link quality statistics block.
// No dependencies; all design files but wlqs_div reference it by scoped names.
package wlqs_pkg;

  localparam int SNR_W      = 16;
  localparam int CFO_W      = 24;
  localparam int RSRP_W     = 16;
  localparam int CNT_W      = 32;
  localparam int LEN_W      = 7;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam int IN_DATA_W  = 56;   // snr, cfo, rsrp
  localparam int IN_USER_W  = 1;    // crc_ok
  localparam int OUT_DATA_W = 264;  // 3 counters + 9 statistics, 33 bytes

  localparam int MAX_WINDOW_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNR_FLOOR  = 1'd1;

  localparam logic [LEN_W-1:0]        WINDOW_LEN_RST = 7'd50;
  localparam logic signed [SNR_W-1:0] SNR_FLOOR_RST  = -16'sd2560;

  // One window entry, held by one cell of the chain.
  typedef struct packed {
    logic signed [RSRP_W-1:0] rsrp;
    logic signed [CFO_W-1:0]  cfo;
    logic signed [SNR_W-1:0]  snr;
  } entry_t;

  // Cell chain control: shift in a new entry, or rotate the ring for a scan.
  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctl_t;

  // Statistics unit control during a scan and at divider start.
  typedef struct packed {
    logic take;
    logic first;
    logic div_start;
  } scan_ctl_t;

endpackage

// File: design/wlqs_cell.sv
`timescale 1ns / 1ps
// One window cell: holds one entry, loads from the previous cell on a shift
// and from the next cell on a rotate. Depends on wlqs_pkg.
module wlqs_cell (
  input  logic                clk,
  input  wlqs_pkg::cell_ctl_t ctl,
  input  wlqs_pkg::entry_t    prev_q,
  input  wlqs_pkg::entry_t    next_q,
  output wlqs_pkg::entry_t    q
);

  wlqs_pkg::entry_t entry_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      entry_r <= prev_q;
    end else if (ctl.rotate) begin
      entry_r <= next_q;
    end
  end

  assign q = entry_r;

endmodule

// File: design/wlqs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for a quotient known to
// fit QW bits. Standalone; used by wlqs_stat.
module wlqs_div #(
  parameter int QW = 16,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend_hi,  // must be below divisor
  input  logic [QW-1:0] dividend_lo,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quot,
  output logic          done
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [QW-1:0] dq_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  assign shifted = {rem_r, dq_r[QW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend_hi;
      dq_r  <= dividend_lo;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      dq_r  <= {dq_r[QW-2:0], ge};
    end
  end

  assign quot = dq_r;
  assign done = done_r;

endmodule

// File: design/wlqs_stat.sv
`timescale 1ns / 1ps
// Sum, minimum and maximum of one metric over a window scan, then the mean
// through an iterative divider. Depends on wlqs_pkg and wlqs_div.
module wlqs_stat #(
  parameter int W          = 16,
  parameter int MAX_WINDOW = wlqs_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wlqs_pkg::scan_ctl_t             ctl,
  input  logic signed [W-1:0]             val,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] fill,
  output logic signed [W-1:0]             mean,
  output logic signed [W-1:0]             min_v,
  output logic signed [W-1:0]             max_v,
  output logic                            done
);

  localparam int FW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = W + FW;

  logic signed [SUMW-1:0] sum_r;
  logic signed [W-1:0]    min_r;
  logic signed [W-1:0]    max_r;
  logic                   neg_r;
  logic signed [SUMW-1:0] val_ext;
  logic [SUMW-1:0]        mag;
  logic [W-1:0]           quot;

  assign val_ext = {{FW{val[W-1]}}, val};
  assign mag     = sum_r[SUMW-1] ? SUMW'(-sum_r) : SUMW'(sum_r);

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      if (ctl.first) begin
        sum_r <= val_ext;
        min_r <= val;
        max_r <= val;
      end else begin
        sum_r <= sum_r + val_ext;
        if (val < min_r) begin
          min_r <= val;
        end
        if (val > max_r) begin
          max_r <= val;
        end
      end
    end
    if (ctl.div_start) begin
      neg_r <= sum_r[SUMW-1];
    end
  end

  wlqs_div #(
    .QW (W),
    .DW (FW)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (ctl.div_start),
    .dividend_hi (mag[SUMW-1:W]),
    .dividend_lo (mag[W-1:0]),
    .divisor     (fill),
    .quot        (quot),
    .done        (done)
  );

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign mean  = neg_r ? -$signed(quot) : $signed(quot);
  assign min_v = min_r;
  assign max_v = max_r;

endmodule

// File: design/windowed_link_quality_stats.sv
`timescale 1ns / 1ps
// Top level of the windowed link quality statistics block: cell chain,
// counters, control sequencer and result register. Depends on wlqs_pkg,
// wlqs_cell and wlqs_stat.
//
// Usage:
//   The in_ channel carries one measurement per request: crc_ok in tuser,
//   SNR, CFO and RSRP in tdata. Each request produces exactly one result on
//   the out_ channel: the saturating total, valid and invalid counts and the
//   mean, minimum and maximum of each metric over the newest valid entries.
//   Window entries live in a chain of MAX_WINDOW cells; a valid request
//   shifts its entry into the head cell. The chain then rotates once around
//   the ring while the head cell feeds the sum, minimum and maximum units,
//   and three dividers then form the means, one bit per cycle. One request
//   is taken at a time: in_tready stays low from accept until the result
//   is loaded into the output register.
//   A finished result waits in the output register; in_tready rises again
//   while it waits, and a new result is held back only while the previous
//   one is still not taken by the receiver.
//   Reset clears counters, fill level, configuration and control; cell
//   contents are left as they are and are never read before being written.
//   Configure only while the block is idle.
module windowed_link_quality_stats #(
  parameter int MAX_WINDOW = wlqs_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata, low bit first: snr_in[15:0], cfo_in[23:0], rsrp_in[15:0]
  input  logic [wlqs_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: crc_ok
  input  logic [wlqs_pkg::IN_USER_W-1:0]      in_tuser,
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata, low bit first: total_count[31:0], valid_count[31:0],
  // invalid_count[31:0], snr_mean, snr_min, snr_max [15:0 each],
  // cfo_mean, cfo_min, cfo_max [23:0 each], rsrp_mean, rsrp_min,
  // rsrp_max [15:0 each]
  output logic [wlqs_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [wlqs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wlqs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FW = $clog2(MAX_WINDOW + 1);
  localparam int KW = $clog2(MAX_WINDOW);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_START = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [KW-1:0] k_r;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] eff_len;
  logic [FW:0]   fill_inc;

  logic [wlqs_pkg::LEN_W-1:0]        window_len_r;
  logic signed [wlqs_pkg::SNR_W-1:0] snr_floor_r;

  logic [wlqs_pkg::CNT_W-1:0] total_r, valid_r, invalid_r;

  logic                              out_valid_r;
  logic [wlqs_pkg::OUT_DATA_W-1:0]   out_data_r;

  logic accept, item_ok, all_done, load, empty;

  wlqs_pkg::entry_t    new_entry;
  wlqs_pkg::entry_t    cell_q [MAX_WINDOW];
  wlqs_pkg::cell_ctl_t cell_ctl;
  wlqs_pkg::scan_ctl_t scan_ctl;

  logic signed [wlqs_pkg::SNR_W-1:0]  snr_mean, snr_min, snr_max;
  logic signed [wlqs_pkg::CFO_W-1:0]  cfo_mean, cfo_min, cfo_max;
  logic signed [wlqs_pkg::RSRP_W-1:0] rsrp_mean, rsrp_min, rsrp_max;
  logic snr_done, cfo_done, rsrp_done;

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign new_entry.snr  = $signed(in_tdata[15:0]);
  assign new_entry.cfo  = $signed(in_tdata[39:16]);
  assign new_entry.rsrp = $signed(in_tdata[55:40]);

  // Valid when the CRC passed and the SNR is at or above the floor.
  assign item_ok = in_tuser[0] && (new_entry.snr >= snr_floor_r);

  // Effective window length: zero acts as one, clamp to the chain size.
  always_comb begin
    if (window_len_r == '0) begin
      eff_len = FW'(1);
    end else if (32'(window_len_r) > MAX_WINDOW) begin
      eff_len = FW'(MAX_WINDOW);
    end else begin
      eff_len = FW'(window_len_r);
    end
  end

  // A valid entry grows the fill by one, or trims it to the window length.
  assign fill_inc = {1'b0, fill_r} + 1'b1;
  always_comb begin
    fill_nxt = fill_r;
    if (accept && item_ok) begin
      fill_nxt = (fill_inc > {1'b0, eff_len}) ? eff_len : fill_inc[FW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= wlqs_pkg::WINDOW_LEN_RST;
      snr_floor_r  <= wlqs_pkg::SNR_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wlqs_pkg::CFG_WINDOW_LEN: window_len_r <= cfg_data[wlqs_pkg::LEN_W-1:0];
        wlqs_pkg::CFG_SNR_FLOOR:  snr_floor_r  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain: shift a valid entry in at the head, rotate during a scan
  // so that the head cell presents entry k in scan cycle k.
  // ---------------------------------------------------------------------
  assign cell_ctl.shift  = accept && item_ok;
  assign cell_ctl.rotate = (state_r == S_SCAN);

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    wlqs_cell u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .prev_q ((i == 0) ? new_entry : cell_q[(i + MAX_WINDOW - 1) % MAX_WINDOW]),
      .next_q (cell_q[(i + 1) % MAX_WINDOW]),
      .q      (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------
  // Statistics units: take only the newest fill_r entries of the ring.
  // ---------------------------------------------------------------------
  assign scan_ctl.take      = (state_r == S_SCAN) && (FW'(k_r) < fill_r);
  assign scan_ctl.first     = (k_r == '0);
  assign scan_ctl.div_start = (state_r == S_START);

  wlqs_stat #(.W(wlqs_pkg::SNR_W), .MAX_WINDOW(MAX_WINDOW)) u_snr (
    .clk (clk), .rst_n (rst_n), .ctl (scan_ctl), .val (cell_q[0].snr),
    .fill (fill_r), .mean (snr_mean), .min_v (snr_min), .max_v (snr_max),
    .done (snr_done)
  );

  wlqs_stat #(.W(wlqs_pkg::CFO_W), .MAX_WINDOW(MAX_WINDOW)) u_cfo (
    .clk (clk), .rst_n (rst_n), .ctl (scan_ctl), .val (cell_q[0].cfo),
    .fill (fill_r), .mean (cfo_mean), .min_v (cfo_min), .max_v (cfo_max),
    .done (cfo_done)
  );

  wlqs_stat #(.W(wlqs_pkg::RSRP_W), .MAX_WINDOW(MAX_WINDOW)) u_rsrp (
    .clk (clk), .rst_n (rst_n), .ctl (scan_ctl), .val (cell_q[0].rsrp),
    .fill (fill_r), .mean (rsrp_mean), .min_v (rsrp_min), .max_v (rsrp_max),
    .done (rsrp_done)
  );

  assign all_done = snr_done && cfo_done && rsrp_done;
  assign load     = (state_r == S_DIV) && all_done && (!out_valid_r || out_tready);
  assign empty    = (fill_r == '0);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (k_r == KW'(MAX_WINDOW - 1)) state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      fill_r    <= '0;
      total_r   <= '0;
      valid_r   <= '0;
      invalid_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (accept) begin
        k_r <= '0;
        if (total_r != '1) total_r <= total_r + 1'b1;
        if (item_ok) begin
          if (valid_r != '1) valid_r <= valid_r + 1'b1;
        end else begin
          if (invalid_r != '1) invalid_r <= invalid_r + 1'b1;
        end
      end else if (state_r == S_SCAN) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register: hold while the receiver stalls.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {
        empty ? '0 : rsrp_max, empty ? '0 : rsrp_min, empty ? '0 : rsrp_mean,
        empty ? '0 : cfo_max,  empty ? '0 : cfo_min,  empty ? '0 : cfo_mean,
        empty ? '0 : snr_max,  empty ? '0 : snr_min,  empty ? '0 : snr_mean,
        invalid_r, valid_r, total_r
      };
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAX_WINDOW)
    else $error("fill level above window capacity");

  a_invalid_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !item_ok) |=> $stable(fill_r))
    else $error("invalid request changed the window fill");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '1) |->
      ({1'b0, total_r} == ({1'b0, valid_r} + {1'b0, invalid_r})))
    else $error("total count differs from valid plus invalid");

  a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DIV && all_done))
    else $error("result presented before the dividers finished");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for windowed_link_quality_stats: drives measurements and
// register writes, predicts each report and checks it field by field.
// Depends on wlqs_pkg and the windowed_link_quality_stats RTL.
module tb;
  import wlqs_pkg::*;

  // Report as it sits on out_tdata; the first member lands in the top bits.
  typedef struct packed {
    logic signed [RSRP_W-1:0] rsrp_max;
    logic signed [RSRP_W-1:0] rsrp_min;
    logic signed [RSRP_W-1:0] rsrp_mean;
    logic signed [CFO_W-1:0]  cfo_max;
    logic signed [CFO_W-1:0]  cfo_min;
    logic signed [CFO_W-1:0]  cfo_mean;
    logic signed [SNR_W-1:0]  snr_max;
    logic signed [SNR_W-1:0]  snr_min;
    logic signed [SNR_W-1:0]  snr_mean;
    logic [CNT_W-1:0]         invalid_count;
    logic [CNT_W-1:0]         valid_count;
    logic [CNT_W-1:0]         total_count;
  } report_t;

  localparam int METRIC_SNR  = 0;
  localparam int METRIC_CFO  = 1;
  localparam int METRIC_RSRP = 2;

  // Tracks the window and counters and keeps the reports still owed.
  class link_quality_tracker;
    int               win [3][MAX_WINDOW_DEF];
    int unsigned      fill;
    int unsigned      slot;
    logic [CNT_W-1:0] total_cnt;
    logic [CNT_W-1:0] valid_cnt;
    logic [CNT_W-1:0] invalid_cnt;
    logic [LEN_W-1:0] win_len;
    int               snr_floor;
    report_t          pending_reports[$];
    int               mismatches;

    function new();
      win_len     = WINDOW_LEN_RST;
      snr_floor   = int'(SNR_FLOOR_RST);
      fill        = 0;
      slot        = 0;
      total_cnt   = '0;
      valid_cnt   = '0;
      invalid_cnt = '0;
      mismatches  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_WINDOW_LEN) win_len = data[LEN_W-1:0];
      else if (idx == CFG_SNR_FLOOR) snr_floor = int'($signed(data));
    endfunction

    // Mean (truncated toward zero), min and max over the newest fill entries.
    function void window_stats(int m, output int avg, output int lo, output int hi);
      longint      sum;
      int          v;
      int unsigned s;
      sum = 0;
      avg = 0;
      lo  = 0;
      hi  = 0;
      s   = slot;
      if (fill == 0) return;
      for (int k = 0; k < fill; k++) begin
        s = (s == 0) ? MAX_WINDOW_DEF - 1 : s - 1;
        v = win[m][s];
        sum += v;
        if (k == 0 || v < lo) lo = v;
        if (k == 0 || v > hi) hi = v;
      end
      avg = int'(sum / longint'(fill));
    endfunction

    function void note_measurement(logic crc, logic signed [SNR_W-1:0] snr,
                                   logic signed [CFO_W-1:0] cfo,
                                   logic signed [RSRP_W-1:0] rsrp);
      report_t     r;
      int          avg, lo, hi;
      int unsigned cap;
      if (total_cnt != '1) total_cnt++;
      if (!crc || snr < snr_floor) begin
        if (invalid_cnt != '1) invalid_cnt++;
      end else begin
        // Zero length acts as one, anything past the store size is clipped.
        cap = (win_len == 0) ? 1 : (win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_len;
        if (valid_cnt != '1) valid_cnt++;
        win[METRIC_SNR][slot]  = int'(snr);
        win[METRIC_CFO][slot]  = int'(cfo);
        win[METRIC_RSRP][slot] = int'(rsrp);
        slot = (slot + 1 >= MAX_WINDOW_DEF) ? 0 : slot + 1;
        fill = (fill + 1 > cap) ? cap : fill + 1;
      end
      r.total_count   = total_cnt;
      r.valid_count   = valid_cnt;
      r.invalid_count = invalid_cnt;
      window_stats(METRIC_SNR, avg, lo, hi);
      r.snr_mean  = avg[SNR_W-1:0];
      r.snr_min   = lo[SNR_W-1:0];
      r.snr_max   = hi[SNR_W-1:0];
      window_stats(METRIC_CFO, avg, lo, hi);
      r.cfo_mean  = avg[CFO_W-1:0];
      r.cfo_min   = lo[CFO_W-1:0];
      r.cfo_max   = hi[CFO_W-1:0];
      window_stats(METRIC_RSRP, avg, lo, hi);
      r.rsrp_mean = avg[RSRP_W-1:0];
      r.rsrp_min  = lo[RSRP_W-1:0];
      r.rsrp_max  = hi[RSRP_W-1:0];
      pending_reports.insert(pending_reports.size(), r);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] data);
      report_t want, got;
      if (pending_reports.size() == 0) begin
        $error("report arrived with no measurement pending");
        mismatches++;
        return;
      end
      want = pending_reports[0];
      pending_reports.delete(0);
      got  = data;
      compare_field("total_count",   want.total_count,   got.total_count);
      compare_field("valid_count",   want.valid_count,   got.valid_count);
      compare_field("invalid_count", want.invalid_count, got.invalid_count);
      compare_field("snr_mean",      want.snr_mean,      got.snr_mean);
      compare_field("snr_min",       want.snr_min,       got.snr_min);
      compare_field("snr_max",       want.snr_max,       got.snr_max);
      compare_field("cfo_mean",      want.cfo_mean,      got.cfo_mean);
      compare_field("cfo_min",       want.cfo_min,       got.cfo_min);
      compare_field("cfo_max",       want.cfo_max,       got.cfo_max);
      compare_field("rsrp_mean",     want.rsrp_mean,     got.rsrp_mean);
      compare_field("rsrp_min",      want.rsrp_min,      got.rsrp_min);
      compare_field("rsrp_max",      want.rsrp_max,      got.rsrp_max);
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  link_quality_tracker meter;
  bit calm         = 1'b0;  // no idling on either side in the closing phase
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off

  windowed_link_quality_stats u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Check every report taken by the receiver against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) meter.check_report(out_tdata);
  end

  // Receiver: mostly ready, random stalls, and one long hold-off on request
  // so the block backs up and stalls its input.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (600) @(negedge clk);
        hold_request = 1'b0;
        out_tready   = 1'b1;
      end else if (!calm && $urandom_range(0, 39) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Watchdog: end the run if the traffic never drains.
  initial begin
    #40_000_000;
    $display("tb: errors");
    $finish;
  end

  // Present one request and hold it until the block takes it; tvalid stays
  // high into the next request unless the caller idles the input.
  task automatic send_measurement(logic crc, logic [SNR_W-1:0] snr,
                                  logic [CFO_W-1:0] cfo, logic [RSRP_W-1:0] rsrp);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = crc;
    in_tdata  = {rsrp, cfo, snr};
    do @(posedge clk); while (!in_tready);
    meter.note_measurement(crc, snr, cfo, rsrp);
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (meter.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    meter.write_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop the last request, then write both registers once the block has gone
  // idle. Bits above the window length field are random and must be ignored.
  task automatic configure(int len, int flr);
    logic [CFG_DATA_W-1:0] d;
    idle_input(1);
    wait_drained();
    repeat (4) @(posedge clk);
    d = CFG_DATA_W'($urandom);
    d[LEN_W-1:0] = len[LEN_W-1:0];
    write_cfg(CFG_WINDOW_LEN, d);
    write_cfg(CFG_SNR_FLOOR, flr[CFG_DATA_W-1:0]);
  endtask

  // Random measurement: mostly good CRC, SNR often near the floor or at the
  // extremes, CFO and RSRP full range with extremes, small values for CFO only.
  task automatic random_measurement();
    logic              crc;
    logic [SNR_W-1:0]  snr;
    logic [CFO_W-1:0]  cfo;
    logic [RSRP_W-1:0] rsrp;
    int                pick, f;
    crc  = ($urandom_range(0, 7) != 0);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      snr = SNR_W'($urandom);
    end else if (pick < 8) begin
      f = meter.snr_floor + int'($urandom_range(0, 6)) - 3;
      if (f > 32767) f = 32767;
      if (f < -32768) f = -32768;
      snr = f[SNR_W-1:0];
    end else begin
      snr = (pick == 8) ? 16'h7FFF : 16'h8000;
    end
    case ($urandom_range(0, 15))
      0:       cfo = 24'h7FFFFF;
      1:       cfo = 24'h800000;
      2:       cfo = 24'(int'($urandom_range(0, 64)) - 32);
      default: cfo = CFO_W'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0:       rsrp = 16'h7FFF;
      1:       rsrp = 16'h8000;
      default: rsrp = RSRP_W'($urandom);
    endcase
    send_measurement(crc, snr, cfo, rsrp);
  endtask

  // One setting of the registers followed by a stretch of random requests.
  task automatic run_phase(int len, int flr, int n, bit hold, bit pause_mid);
    configure(len, flr);
    if (hold) hold_request = 1'b1;
    for (int i = 0; i < n; i++) begin
      random_measurement();
      if (pause_mid && i == n / 2) begin
        // Hold the sender until every report is back.
        idle_input(1);
        wait_drained();
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        // Let the block drain, then idle so the gap meets its ready window.
        idle_input(1);
        wait_drained();
        idle_input($urandom_range(1, 16));
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        idle_input($urandom_range(1, 16));
      end
    end
  endtask

  initial begin
    meter = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings (window 50, floor -10 dB). The empty window
    // comes first, then the floor boundary and the field extremes.
    send_measurement(1'b0, 16'h0000, 24'h000000, 16'h0000);
    send_measurement(1'b1, -16'sd2561, 24'h000010, 16'h0100);
    send_measurement(1'b1, 16'h8000, 24'h000020, 16'h0200);
    send_measurement(1'b0, 16'h7FFF, 24'h7FFFFF, 16'h7FFF);
    send_measurement(1'b1, -16'sd2560, 24'h800000, 16'h8000);
    send_measurement(1'b1, 16'h7FFF, 24'h7FFFFF, 16'h7FFF);
    send_measurement(1'b1, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
    send_measurement(1'b1, 16'h0001, 24'h000001, 16'h0001);
    send_measurement(1'b1, -16'sd2559, 24'h800001, 16'h8001);
    send_measurement(1'b1, 16'h5555, 24'h555555, 16'h5555);
    send_measurement(1'b1, 16'h2AAA, 24'hAAAAAA, 16'hAAAA);
    idle_input(1);

    // Full window with the long receiver hold-off, then a shrink, the zero
    // and oversize lengths, a grow from one, and a mid-phase sender pause.
    run_phase(64, -32768, 300, 1'b1, 1'b0);
    run_phase(5, -2560, 180, 1'b0, 1'b0);
    run_phase(0, 32767, 140, 1'b0, 1'b0);
    run_phase(127, 0, 220, 1'b0, 1'b0);
    run_phase(1, -32768, 140, 1'b0, 1'b0);
    run_phase(33, int'($urandom_range(0, 8000)) - 4000, 220, 1'b0, 1'b1);
    run_phase(2, 1000, 160, 1'b0, 1'b0);
    calm = 1'b1;
    run_phase(64, -2560, 330, 1'b0, 1'b0);
    idle_input(1);

    // Drain, then give any stray report time to show up.
    wait_drained();
    repeat (120) @(posedge clk);
    if (meter.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
